// ----- design/byte_ring_fifo_with_line_search_defines.svh -----
// Assertion macros for the byte ring FIFO design; only the top level includes them.
// Each macro expects clk and rst in scope and reports through $error.
`ifndef BYTE_RING_FIFO_WITH_LINE_SEARCH_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_LINE_SEARCH_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define BRFLS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define BRFLS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define BRFLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/brfls_pkg.sv -----
// Shared types and constants for the byte ring FIFO with line-end search.
// No dependencies; every other design file but the defines header imports this package.
package brfls_pkg;

  localparam int DATA_W  = 8;
  localparam int OP_W    = 3;
  localparam int FIELD_W = 8;

  localparam logic [DATA_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [DATA_W-1:0] CHAR_LF = 8'h0A;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_UNPUSH = 3'd2,
    OP_FLUSH  = 3'd3,
    OP_FIND   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDWAIT,
    S_SCAN,
    S_DONE
  } state_t;

  // Strobes from the sequencer to the byte store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  function automatic logic is_line_end(input logic [DATA_W-1:0] b);
    return (b == CHAR_CR) || (b == CHAR_LF);
  endfunction

endpackage

// ----- design/brfls_in_if.sv -----
// Request channel: one operation code and one byte per word.
// Depends on brfls_pkg for field widths.
interface brfls_in_if import brfls_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, operation, data_in, input ready);
  modport sink   (input valid, operation, data_in, output ready);
endinterface

// ----- design/brfls_out_if.sv -----
// Response channel: status, removed byte, line-end result and fill count.
// Depends on brfls_pkg for field widths.
interface brfls_out_if import brfls_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [DATA_W-1:0]  data_out;
  logic               eol_found;
  logic [FIELD_W-1:0] eol_index;
  logic [FIELD_W-1:0] fill_count;

  modport source (output valid, ok, data_out, eol_found, eol_index, fill_count,
                  input ready);
  modport sink   (input valid, ok, data_out, eol_found, eol_index, fill_count,
                  output ready);
endinterface

// ----- design/brfls_store.sv -----
// Slot memory of the ring: a byte and its line-end mark per slot.
// One write port, one read port with registered read data. Uses brfls_pkg.
module brfls_store import brfls_pkg::*; #(
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic              clk,
  input  mem_ctl_t          ctl,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_byte,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_byte,
  output logic              rd_mark
);

  logic [DATA_W:0] mem [DEPTH];
  logic [DATA_W:0] rd_word;

  // The mark is derived once, at push time, so the search only reads one bit.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {is_line_end(wr_byte), wr_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_byte = rd_word[DATA_W-1:0];
  assign rd_mark = rd_word[DATA_W];

endmodule

// ----- design/byte_ring_fifo_with_line_search.sv -----
// Top level of the byte ring FIFO with line-end search.
// Depends on brfls_pkg, brfls_in_if, brfls_out_if, brfls_store and the defines header.
//
//   channel | dir | word contents
//   --------+-----+-----------------------------------------------------
//   req     | in  | operation, data_in
//   rsp     | out | ok, data_out, eol_found, eol_index, fill_count
//
// Push, flush, unknown codes, and pop, unpush or find on an empty ring go straight to done.
// Pop and unpush on a ring that holds a byte pass through the read-wait state first.
// Find stops at the first line-end mark; the single memory read port checks one slot a cycle.
// Reset clears state, pointers, count and flags only; no slot is read before a push writes it.
// A result waits in the output register while the next word is taken; if it is still
// held when the following result is ready, the sequencer holds until rsp accepts.
module byte_ring_fifo_with_line_search import brfls_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  brfls_in_if.sink    req,
  brfls_out_if.source rsp
);

`include "byte_ring_fifo_with_line_search_defines.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int WW = (AW > FIELD_W) ? AW : FIELD_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  state_t        state, state_next;
  logic [AW-1:0] head, tail, count;
  logic [AW-1:0] scan_addr, scan_left, pend_slot;
  logic          pend;

  logic               res_ok, res_found;
  logic [DATA_W-1:0]  res_data;
  logic [AW-1:0]      res_idx;

  logic               rsp_valid;
  logic               out_ok, out_found;
  logic [DATA_W-1:0]  out_data;
  logic [FIELD_W-1:0] out_idx, out_fill;

  mem_ctl_t          ctl;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_byte;
  logic              rd_mark;

  logic          accept, has_room, not_empty, out_free, res_load;
  logic          scan_issue, scan_hit, scan_miss_end;
  op_t           op;
  logic [WW-1:0] idx_w, count_w;
  logic [AW:0]   ring_span;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
    return (s == LAST) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] s);
    return (s == '0) ? LAST : s - 1'b1;
  endfunction

  assign op        = op_t'(req.operation);
  assign accept    = req.valid && req.ready;
  assign has_room  = count != LAST;
  assign not_empty = count != '0;
  assign out_free  = !rsp_valid || rsp.ready;

  // The scan checks the slot read in the previous cycle while the next read is issued.
  assign scan_issue    = (state == S_SCAN) && (scan_left != '0);
  assign scan_hit      = pend && rd_mark;
  assign scan_miss_end = pend && !rd_mark && (scan_left == '0);

  brfls_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .ctl     (ctl),
    .wr_addr (tail),
    .wr_byte (req.data_in),
    .rd_addr (rd_addr),
    .rd_byte (rd_byte),
    .rd_mark (rd_mark)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_POP, OP_UNPUSH: state_next = not_empty ? S_RDWAIT : S_DONE;
            OP_FIND:           state_next = not_empty ? S_SCAN : S_DONE;
            default:           state_next = S_DONE;
          endcase
        end
      end
      S_RDWAIT: state_next = S_DONE;
      S_SCAN: begin
        if (scan_hit || scan_miss_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and memory strobes.
  always_comb begin
    req.ready  = (state == S_IDLE);
    res_load   = (state == S_DONE) && out_free;
    ctl.wr_en  = 1'b0;
    ctl.rd_en  = 1'b0;
    rd_addr    = scan_addr;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_PUSH: ctl.wr_en = has_room;
            OP_POP: begin
              ctl.rd_en = not_empty;
              rd_addr   = head;
            end
            OP_UNPUSH: begin
              ctl.rd_en = not_empty;
              rd_addr   = prev_slot(tail);
            end
            default: ;
          endcase
        end
      end
      S_SCAN:   ctl.rd_en = scan_issue;
      S_RDWAIT: ;
      S_DONE:   ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= scan_issue;
      if (accept) begin
        unique case (op)
          OP_PUSH: begin
            if (has_room) begin
              tail  <= next_slot(tail);
              count <= count + 1'b1;
            end
          end
          OP_POP: begin
            if (not_empty) begin
              head  <= next_slot(head);
              count <= count - 1'b1;
            end
          end
          OP_UNPUSH: begin
            if (not_empty) begin
              tail  <= prev_slot(tail);
              count <= count - 1'b1;
            end
          end
          OP_FLUSH: begin
            head  <= tail;
            count <= '0;
          end
          default: ;
        endcase
      end
      if (res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result and scan payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_data  <= '0;
      res_found <= 1'b0;
      res_idx   <= '0;
      scan_addr <= head;
      scan_left <= count;
      unique case (op)
        OP_PUSH:           res_ok <= has_room;
        OP_POP, OP_UNPUSH: res_ok <= not_empty;
        OP_FLUSH, OP_FIND: res_ok <= 1'b1;
        default:           res_ok <= 1'b0;
      endcase
    end
    if (state == S_RDWAIT) begin
      res_data <= rd_byte;
    end
    if (scan_issue) begin
      scan_addr <= next_slot(scan_addr);
      scan_left <= scan_left - 1'b1;
      pend_slot <= scan_addr;
    end
    if ((state == S_SCAN) && scan_hit) begin
      res_found <= 1'b1;
      res_idx   <= pend_slot;
    end
    if (res_load) begin
      out_ok    <= res_ok;
      out_data  <= res_data;
      out_found <= res_found;
      out_idx   <= idx_w[FIELD_W-1:0];
      out_fill  <= count_w[FIELD_W-1:0];
    end
  end

  assign idx_w   = WW'(res_idx);
  assign count_w = WW'(count);

  assign rsp.valid      = rsp_valid;
  assign rsp.ok         = out_ok;
  assign rsp.data_out   = out_data;
  assign rsp.eol_found  = out_found;
  assign rsp.eol_index  = out_idx;
  assign rsp.fill_count = out_fill;

  // Distance from head to tail around the ring, for the consistency check.
  assign ring_span = (tail >= head) ? ((AW+1)'(tail) - (AW+1)'(head))
                                    : ((AW+1)'(DEPTH) - (AW+1)'(head) + (AW+1)'(tail));

  `BRFLS_ASSERT(a_count_bound, count <= LAST, "fill count exceeds ring capacity")
  `BRFLS_ASSERT(a_count_matches_ptrs, (AW+1)'(count) == ring_span,
                "fill count disagrees with head and tail")
  `BRFLS_ASSERT_IMPL(a_scan_progress, state == S_SCAN, (scan_left != '0) || pend,
                     "line-end scan has nothing left to check")
  `BRFLS_ASSERT_NEXT(a_pop_count, accept && (op == OP_POP) && not_empty,
                     count == $past(count) - 1'b1, "pop did not lower the fill count")

endmodule
